// File: sv/assert_macros.svh
// assertion macros shared by the rtl files
// each macro expects clk and rst_n in scope
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// consequent must hold in the same cycle as the antecedent
`define ASSERT_IMPLIES(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// consequent must hold in the cycle after the antecedent
`define ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// File: sv/mstw_pkg.sv
// ----------------------------------------------------------------------------
// mstw_pkg
// Shared constants, state types and control structs of the spanning tree block.
// ----------------------------------------------------------------------------
package mstw_pkg;

    localparam int DEF_MAX_NODES   = 1024;
    localparam int DEF_MAX_EDGES   = 4096;
    localparam int DEF_WEIGHT_BITS = 16;

    localparam int NODE_W  = 10;
    localparam int SUM_W   = 26;
    localparam int COUNT_W = 10;
    localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};

    localparam int S_DATA_W = 40;
    localparam int M_DATA_W = 40;

    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;
    // register index bit of the byte address
    localparam logic REG_NODE_COUNT = 1'b0;

    typedef enum logic [2:0] {
        S_LOAD,
        S_CLEAR,
        S_START,
        S_RD,
        S_EV,
        S_UF,
        S_NEXT,
        S_FINISH
    } ctl_state_t;

    typedef enum logic [2:0] {
        U_IDLE,
        U_CLEAR,
        U_FIND_RD,
        U_FIND_CHK,
        U_COMP_RD,
        U_COMP_CHK,
        U_LINK
    } uf_state_t;

    typedef struct packed {
        logic              clear;
        logic              unite;
        logic [NODE_W-1:0] node_a;
        logic [NODE_W-1:0] node_b;
    } uf_req_t;

    typedef struct packed {
        logic done;
        logic joined;
    } uf_rsp_t;

endpackage

// File: sv/mstw_edge_mem.sv
// ----------------------------------------------------------------------------
// mstw_edge_mem
// Edge list store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module mstw_edge_mem #(
    parameter int DEPTH  = mstw_pkg::DEF_MAX_EDGES,
    parameter int WIDTH  = mstw_pkg::DEF_WEIGHT_BITS + 2 * mstw_pkg::NODE_W,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// File: sv/mstw_uf.sv
// ----------------------------------------------------------------------------
// mstw_uf
// Union-find engine over the parent memory: clearing sweep, root search with
// path compression, and linking of two roots.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module mstw_uf #(
    parameter int MAX_NODES = mstw_pkg::DEF_MAX_NODES
) (
    input  logic              clk,
    input  logic              rst_n,
    input  mstw_pkg::uf_req_t req,
    output mstw_pkg::uf_rsp_t rsp
);

    localparam int NB = $clog2(MAX_NODES);
    localparam logic [NB-1:0] LAST_NODE = NB'(MAX_NODES - 1);

    logic [NB-1:0] parent_mem [MAX_NODES];
    logic [NB-1:0] rd_q;

    mstw_pkg::uf_state_t state_reg, state_next;
    logic [NB-1:0] x_reg, x_next;
    logic [NB-1:0] root_reg, root_next;
    logic [NB-1:0] root_a_reg, root_a_next;
    logic [NB-1:0] b_reg, b_next;
    logic [NB-1:0] a_reg, a_next;
    logic          side_reg, side_next;
    logic [NB-1:0] clr_reg, clr_next;
    logic          done_reg, done_next;
    logic          joined_reg, joined_next;

    logic          we;
    logic [NB-1:0] wa, wd, ra;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            parent_mem[wa] <= wd;
        end
        rd_q <= parent_mem[ra];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= mstw_pkg::U_IDLE;
            done_reg   <= 1'b0;
            joined_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            done_reg   <= done_next;
            joined_reg <= joined_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg      <= x_next;
        root_reg   <= root_next;
        root_a_reg <= root_a_next;
        a_reg      <= a_next;
        b_reg      <= b_next;
        side_reg   <= side_next;
        clr_reg    <= clr_next;
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            mstw_pkg::U_IDLE:
            begin
                if (req.clear)
                begin
                    state_next = mstw_pkg::U_CLEAR;
                end
                else if (req.unite)
                begin
                    state_next = mstw_pkg::U_FIND_RD;
                end
            end
            mstw_pkg::U_CLEAR:
            begin
                if (clr_reg == LAST_NODE)
                begin
                    state_next = mstw_pkg::U_IDLE;
                end
            end
            mstw_pkg::U_FIND_RD:  state_next = mstw_pkg::U_FIND_CHK;
            mstw_pkg::U_FIND_CHK:
            begin
                if (rd_q == x_reg)
                begin
                    state_next = mstw_pkg::U_COMP_RD;
                end
            end
            mstw_pkg::U_COMP_RD:  state_next = mstw_pkg::U_COMP_CHK;
            mstw_pkg::U_COMP_CHK:
            begin
                if (rd_q == root_reg)
                begin
                    state_next = side_reg ? mstw_pkg::U_LINK : mstw_pkg::U_FIND_RD;
                end
            end
            mstw_pkg::U_LINK:     state_next = mstw_pkg::U_IDLE;
            default:              state_next = mstw_pkg::U_IDLE;
        endcase
    end

    // datapath and memory control
    always_comb
    begin
        x_next      = x_reg;
        root_next   = root_reg;
        root_a_next = root_a_reg;
        a_next      = a_reg;
        b_next      = b_reg;
        side_next   = side_reg;
        clr_next    = clr_reg;
        done_next   = 1'b0;
        joined_next = 1'b0;
        we          = 1'b0;
        wa          = clr_reg;
        wd          = clr_reg;
        ra          = x_reg;
        case (state_reg)
            mstw_pkg::U_IDLE:
            begin
                clr_next  = '0;
                a_next    = NB'(req.node_a);
                b_next    = NB'(req.node_b);
                x_next    = NB'(req.node_a);
                side_next = 1'b0;
            end
            mstw_pkg::U_CLEAR:
            begin
                we       = 1'b1;
                clr_next = clr_reg + 1'b1;
                if (clr_reg == LAST_NODE)
                begin
                    done_next = 1'b1;
                end
            end
            mstw_pkg::U_FIND_RD:
            begin
                ra = x_reg;
            end
            mstw_pkg::U_FIND_CHK:
            begin
                if (rd_q == x_reg)
                begin
                    root_next = x_reg;
                    x_next    = side_reg ? b_reg : a_reg;
                end
                else
                begin
                    x_next = rd_q;
                    ra     = rd_q;
                end
            end
            mstw_pkg::U_COMP_RD:
            begin
                ra = x_reg;
            end
            mstw_pkg::U_COMP_CHK:
            begin
                if (rd_q == root_reg)
                begin
                    if (!side_reg)
                    begin
                        root_a_next = root_reg;
                        side_next   = 1'b1;
                        x_next      = b_reg;
                    end
                end
                else
                begin
                    // point this node straight at the root and move on
                    we     = 1'b1;
                    wa     = x_reg;
                    wd     = root_reg;
                    x_next = rd_q;
                    ra     = rd_q;
                end
            end
            mstw_pkg::U_LINK:
            begin
                done_next = 1'b1;
                if (root_a_reg != root_reg)
                begin
                    we          = 1'b1;
                    wa          = root_a_reg;
                    wd          = root_reg;
                    joined_next = 1'b1;
                end
            end
            default:
            begin
            end
        endcase
    end

    assign rsp.done   = done_reg;
    assign rsp.joined = joined_reg;

    `ASSERT_IMPLIES(a_uf_req_idle, req.unite || req.clear, state_reg == mstw_pkg::U_IDLE)
    `ASSERT_IMPLIES(a_uf_no_rw_clash, state_reg == mstw_pkg::U_COMP_CHK && we, wa != ra)

endmodule

// File: sv/minimum_spanning_tree_weight.sv
// ----------------------------------------------------------------------------
// minimum_spanning_tree_weight
// Kruskal spanning tree weight over a loaded edge list, union-find in memory.
// ----------------------------------------------------------------------------
//  channel   dir   handshake                    contents
//  s_*       in    s_tvalid/s_tready            one edge, s_tlast ends the list
//  m_*       out   m_tvalid/m_tready            one result per list
//  apb       in    psel/penable/pwrite, pready  node_count at byte address 0
//
//  loading takes one edge per cycle; s_tready is low from the final edge
//  until the result is built. the build sweeps the parent memory, then
//  makes one pass over the stored edges per distinct weight, plus a pass at
//  weight zero when no edge carries it; each pass reads the stored edges in
//  turn, with the union-find memory walks of each edge of the current
//  weight. rst_n clears all control state. the
//  result waits in an output register, so a stalled m_tready holds only the
//  next result, not the next load.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module minimum_spanning_tree_weight #(
    parameter int MAX_NODES   = mstw_pkg::DEF_MAX_NODES,
    parameter int MAX_EDGES   = mstw_pkg::DEF_MAX_EDGES,
    parameter int WEIGHT_BITS = mstw_pkg::DEF_WEIGHT_BITS
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [mstw_pkg::APB_ADDR_W-1:0]     paddr,
    input  logic [mstw_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [mstw_pkg::APB_DATA_W-1:0]     prdata,
    output logic                                pready,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // node_a[9:0], node_b[19:10], edge_weight[35:20], zero pad
    input  logic [mstw_pkg::S_DATA_W-1:0]       s_tdata,
    input  logic                                s_tlast,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // total_weight[25:0], edges_taken[35:26], connected[36], overflow[37], zero pad
    output logic [mstw_pkg::M_DATA_W-1:0]       m_tdata
);

    localparam int NW      = mstw_pkg::NODE_W;
    localparam int EW      = WEIGHT_BITS + 2 * NW;
    localparam int ADDR_W  = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
    localparam int FILL_W  = $clog2(MAX_EDGES + 1);
    localparam int CW      = mstw_pkg::COUNT_W;
    localparam int SW      = mstw_pkg::SUM_W;
    localparam int LIMIT_CAP = MAX_NODES - 1;
    localparam logic [FILL_W-1:0] FILL_FULL = FILL_W'(MAX_EDGES);

    mstw_pkg::ctl_state_t state_reg, state_next;

    logic [NW-1:0]          node_count_reg;
    logic [FILL_W-1:0]      fill_reg, fill_next;
    logic                   lost_reg, lost_next;
    logic [FILL_W-1:0]      idx_reg, idx_next;
    logic [NW-1:0]          limit_reg, limit_next;
    logic [CW-1:0]          target_reg, target_next;
    logic [CW-1:0]          joined_reg, joined_next;
    logic [SW-1:0]          sum_reg, sum_next;
    logic [WEIGHT_BITS-1:0] cur_w_reg, cur_w_next;
    logic [WEIGHT_BITS-1:0] nxt_w_reg, nxt_w_next;
    logic                   found_reg, found_next;
    logic                   m_tvalid_reg, m_tvalid_next;
    logic [mstw_pkg::M_DATA_W-1:0] m_tdata_reg, m_tdata_next;

    logic                   s_xfer;
    logic                   cfg_wr;
    logic [NW-1:0]          limit_in;
    logic                   em_we;
    logic [EW-1:0]          em_wdata;
    logic [EW-1:0]          em_rdata;
    logic [WEIGHT_BITS-1:0] e_w;
    logic [NW-1:0]          e_a, e_b;
    logic                   e_ok;
    logic [SW:0]            sum_wide;
    logic                   pass_end;
    mstw_pkg::uf_req_t      uf_req;
    mstw_pkg::uf_rsp_t      uf_rsp;

    // configuration port
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr[2] == mstw_pkg::REG_NODE_COUNT);
    assign prdata = (paddr[2] == mstw_pkg::REG_NODE_COUNT)
                  ? mstw_pkg::APB_DATA_W'(node_count_reg) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            node_count_reg <= NW'(1);
        end
        else if (cfg_wr)
        begin
            node_count_reg <= pwdata[NW-1:0];
        end
    end

    assign s_tready = (state_reg == mstw_pkg::S_LOAD);
    assign s_xfer   = s_tvalid && s_tready;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    assign limit_in = (32'(node_count_reg) > LIMIT_CAP) ? NW'(LIMIT_CAP) : node_count_reg;

    assign em_we    = s_xfer && (fill_reg != FILL_FULL);
    assign em_wdata = {WEIGHT_BITS'(s_tdata[35:20]), s_tdata[9:0], s_tdata[19:10]};

    mstw_edge_mem #(
        .DEPTH  (MAX_EDGES),
        .WIDTH  (EW),
        .ADDR_W (ADDR_W)
    ) u_edge_mem (
        .clk   (clk),
        .we    (em_we),
        .waddr (fill_reg[ADDR_W-1:0]),
        .wdata (em_wdata),
        .raddr (idx_reg[ADDR_W-1:0]),
        .rdata (em_rdata)
    );

    assign e_b = em_rdata[NW-1:0];
    assign e_a = em_rdata[2*NW-1:NW];
    assign e_w = em_rdata[EW-1:2*NW];
    assign e_ok = (e_a != '0) && (e_b != '0) && (e_a <= limit_reg) && (e_b <= limit_reg);

    assign pass_end = (idx_reg + 1'b1) == fill_reg;
    assign sum_wide = (SW + 1)'(sum_reg) + (SW + 1)'(cur_w_reg);

    mstw_uf #(
        .MAX_NODES (MAX_NODES)
    ) u_uf (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (uf_req),
        .rsp   (uf_rsp)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= mstw_pkg::S_LOAD;
            fill_reg     <= '0;
            lost_reg     <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            fill_reg     <= fill_next;
            lost_reg     <= lost_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg     <= idx_next;
        limit_reg   <= limit_next;
        target_reg  <= target_next;
        joined_reg  <= joined_next;
        sum_reg     <= sum_next;
        cur_w_reg   <= cur_w_next;
        nxt_w_reg   <= nxt_w_next;
        found_reg   <= found_next;
        m_tdata_reg <= m_tdata_next;
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            mstw_pkg::S_LOAD:
            begin
                if (s_xfer && s_tlast)
                begin
                    state_next = mstw_pkg::S_CLEAR;
                end
            end
            mstw_pkg::S_CLEAR:
            begin
                if (uf_rsp.done)
                begin
                    state_next = mstw_pkg::S_START;
                end
            end
            mstw_pkg::S_START:
            begin
                state_next = (joined_reg == target_reg) ? mstw_pkg::S_FINISH : mstw_pkg::S_RD;
            end
            mstw_pkg::S_RD: state_next = mstw_pkg::S_EV;
            mstw_pkg::S_EV:
            begin
                state_next = (e_ok && e_w == cur_w_reg) ? mstw_pkg::S_UF : mstw_pkg::S_NEXT;
            end
            mstw_pkg::S_UF:
            begin
                if (uf_rsp.done)
                begin
                    state_next = mstw_pkg::S_NEXT;
                end
            end
            mstw_pkg::S_NEXT:
            begin
                if (joined_reg == target_reg)
                begin
                    state_next = mstw_pkg::S_FINISH;
                end
                else if (pass_end && !found_reg)
                begin
                    state_next = mstw_pkg::S_FINISH;
                end
                else
                begin
                    state_next = mstw_pkg::S_RD;
                end
            end
            mstw_pkg::S_FINISH:
            begin
                if (!m_tvalid_reg || m_tready)
                begin
                    state_next = mstw_pkg::S_LOAD;
                end
            end
            default: state_next = mstw_pkg::S_LOAD;
        endcase
    end

    // datapath and outputs
    always_comb
    begin
        fill_next     = fill_reg;
        lost_next     = lost_reg;
        idx_next      = idx_reg;
        limit_next    = limit_reg;
        target_next   = target_reg;
        joined_next   = joined_reg;
        sum_next      = sum_reg;
        cur_w_next    = cur_w_reg;
        nxt_w_next    = nxt_w_reg;
        found_next    = found_reg;
        m_tdata_next  = m_tdata_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        uf_req.clear  = 1'b0;
        uf_req.unite  = 1'b0;
        uf_req.node_a = e_a;
        uf_req.node_b = e_b;
        case (state_reg)
            mstw_pkg::S_LOAD:
            begin
                if (s_xfer)
                begin
                    if (fill_reg != FILL_FULL)
                    begin
                        fill_next = fill_reg + 1'b1;
                    end
                    else
                    begin
                        lost_next = 1'b1;
                    end
                    if (s_tlast)
                    begin
                        uf_req.clear = 1'b1;
                        limit_next   = limit_in;
                        target_next  = (limit_in == '0) ? '0 : CW'(limit_in - 1'b1);
                        joined_next  = '0;
                        sum_next     = '0;
                    end
                end
            end
            mstw_pkg::S_START:
            begin
                idx_next   = '0;
                cur_w_next = '0;
                found_next = 1'b0;
            end
            mstw_pkg::S_EV:
            begin
                if (e_ok && e_w == cur_w_reg)
                begin
                    uf_req.unite = 1'b1;
                end
                else if (e_w > cur_w_reg && (!found_reg || e_w < nxt_w_reg))
                begin
                    // smallest weight above the current pass
                    nxt_w_next = e_w;
                    found_next = 1'b1;
                end
            end
            mstw_pkg::S_UF:
            begin
                if (uf_rsp.done && uf_rsp.joined)
                begin
                    joined_next = joined_reg + 1'b1;
                    sum_next    = (sum_wide > (SW + 1)'(mstw_pkg::SUM_MAX))
                                ? mstw_pkg::SUM_MAX : sum_wide[SW-1:0];
                end
            end
            mstw_pkg::S_NEXT:
            begin
                if (pass_end)
                begin
                    idx_next   = '0;
                    cur_w_next = nxt_w_reg;
                    found_next = 1'b0;
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            mstw_pkg::S_FINISH:
            begin
                if (!m_tvalid_reg || m_tready)
                begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {2'b00, lost_reg, (joined_reg == target_reg),
                                     joined_reg, sum_reg};
                    fill_next     = '0;
                    lost_next     = 1'b0;
                end
            end
            default:
            begin
            end
        endcase
    end

    `ASSERT_IMPLIES(a_joined_bound, state_reg != mstw_pkg::S_LOAD, joined_reg <= target_reg)
    `ASSERT_IMPLIES(a_scan_in_fill, state_reg == mstw_pkg::S_RD, idx_reg < fill_reg)

endmodule

// File: sim/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the spanning tree weight block. Edge lists are
// streamed in with random gaps, results are taken with random stalls, and
// each result is compared field by field against a Kruskal predictor.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic [15:0]                 wt;
        logic [mstw_pkg::NODE_W-1:0] na;
        logic [mstw_pkg::NODE_W-1:0] nb;
    } edge_t;

    typedef struct {
        logic [mstw_pkg::SUM_W-1:0]   total;
        logic [mstw_pkg::COUNT_W-1:0] taken;
        logic                         conn;
        logic                         ovf;
    } tree_res_t;

    class spanning_sum_board;
        edge_t       stored[$];
        bit          lost;
        int          nodes;
        int          errors;
        tree_res_t   pending[$];

        function new();
            nodes  = 1;
            errors = 0;
            lost   = 0;
        endfunction

        function int find_root(ref int par[mstw_pkg::DEF_MAX_NODES], input int x);
            while (par[x] != x)
                x = par[x];
            return x;
        endfunction

        function void note_edge(edge_t e, bit last);
            int        par[mstw_pkg::DEF_MAX_NODES];
            int        lim;
            int        target;
            int        ra;
            int        rb;
            int        joined;
            longint    sum;
            edge_t     srt[$];
            edge_t     tmp;
            int        j;
            tree_res_t r;
            if (stored.size() < mstw_pkg::DEF_MAX_EDGES)
                stored.push_back(e);
            else
                lost = 1;
            if (!last)
                return;
            lim = (nodes > mstw_pkg::DEF_MAX_NODES - 1) ? mstw_pkg::DEF_MAX_NODES - 1 : nodes;
            target = (lim > 0) ? lim - 1 : 0;
            for (int i = 0; i < mstw_pkg::DEF_MAX_NODES; i++)
                par[i] = i;
            // insertion sort by weight, tie order does not matter
            srt = stored;
            for (int i = 1; i < srt.size(); i++)
            begin
                tmp = srt[i];
                j = i - 1;
                while (j >= 0 && srt[j].wt > tmp.wt)
                begin
                    srt[j+1] = srt[j];
                    j--;
                end
                srt[j+1] = tmp;
            end
            joined = 0;
            sum = 0;
            for (int i = 0; i < srt.size() && joined < target; i++)
            begin
                if (srt[i].na == 0 || srt[i].nb == 0 || srt[i].na > lim || srt[i].nb > lim)
                    continue;
                ra = find_root(par, srt[i].na);
                rb = find_root(par, srt[i].nb);
                if (ra == rb)
                    continue;
                par[ra] = rb;
                joined++;
                sum += srt[i].wt;
            end
            r.total = (sum > mstw_pkg::SUM_MAX) ? mstw_pkg::SUM_MAX : sum[mstw_pkg::SUM_W-1:0];
            r.taken = joined[mstw_pkg::COUNT_W-1:0];
            r.conn  = (joined == target);
            r.ovf   = lost;
            pending.push_back(r);
            stored.delete();
            lost = 0;
        endfunction

        function void check_result(logic [mstw_pkg::M_DATA_W-1:0] d);
            tree_res_t x;
            if (pending.size() == 0)
            begin
                $display("%0t unexpected result: exp none act %h", $realtime, d);
                errors++;
                return;
            end
            x = pending.pop_front();
            if (d[25:0] !== x.total)
            begin
                $display("%0t total_weight: exp %0d act %0d", $realtime, x.total, d[25:0]);
                errors++;
            end
            if (d[35:26] !== x.taken)
            begin
                $display("%0t edges_taken: exp %0d act %0d", $realtime, x.taken, d[35:26]);
                errors++;
            end
            if (d[36] !== x.conn)
            begin
                $display("%0t connected: exp %0d act %0d", $realtime, x.conn, d[36]);
                errors++;
            end
            if (d[37] !== x.ovf)
            begin
                $display("%0t overflow: exp %0d act %0d", $realtime, x.ovf, d[37]);
                errors++;
            end
        endfunction
    endclass

    logic                            clk;
    logic                            rst_n;
    logic                            psel;
    logic                            penable;
    logic                            pwrite;
    logic [mstw_pkg::APB_ADDR_W-1:0] paddr;
    logic [mstw_pkg::APB_DATA_W-1:0] pwdata;
    logic [mstw_pkg::APB_DATA_W-1:0] prdata;
    logic                            pready;
    logic                            s_tvalid;
    logic                            s_tready;
    // node_a[9:0], node_b[19:10], edge_weight[35:20], zero pad
    logic [mstw_pkg::S_DATA_W-1:0]   s_tdata;
    logic                            s_tlast;
    logic                            m_tvalid;
    logic                            m_tready;
    // total_weight[25:0], edges_taken[35:26], connected[36], overflow[37], zero pad
    logic [mstw_pkg::M_DATA_W-1:0]   m_tdata;

    spanning_sum_board sb;
    int                hold_off;
    int                sent;

    minimum_spanning_tree_weight i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial clk = 1'b0;
    always #6 clk = ~clk;

    task automatic write_node_count(int v);
        @(negedge clk);
        psel    = 1'b1;
        pwrite  = 1'b1;
        paddr   = '0;
        pwdata  = v;
        penable = 1'b0;
        @(negedge clk);
        penable = 1'b1;
        do
            @(posedge clk);
        while (!pready);
        sb.nodes = v;
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    task automatic send_edge(int a, int b, int w, bit last);
        int    gap;
        edge_t e;
        gap = $urandom_range(0, 4);
        if (gap > 0)
        begin
            s_tvalid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tdata  = {4'b0, w[15:0], b[9:0], a[9:0]};
        s_tlast  = last;
        s_tvalid = 1'b1;
        do
            @(posedge clk);
        while (!s_tready);
        e.wt = w[15:0];
        e.na = a[9:0];
        e.nb = b[9:0];
        sb.note_edge(e, last);
        sent++;
        @(negedge clk);
    endtask

    // settle between phases: all results back, then a margin
    task automatic drain();
        @(negedge clk);
        s_tvalid = 1'b0;
        while (sb.pending.size() != 0)
            @(negedge clk);
        repeat (20) @(negedge clk);
    endtask

    function automatic int pick_node(int nc);
        if ($urandom_range(0, 4) == 0 || nc < 1)
            return $urandom_range(0, 1023);
        return $urandom_range(1, nc);
    endfunction

    task automatic random_list(int nc);
        int len;
        int w;
        len = $urandom_range(1, 12);
        for (int i = 0; i < len; i++)
        begin
            w = $urandom_range(0, 1) ? $urandom_range(0, 15) : $urandom_range(0, 65535);
            send_edge(pick_node(nc), pick_node(nc), w, i == len - 1);
        end
    endtask

    // receiver: random stalls, plus one long hold when asked
    initial
    begin
        m_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_off > 0)
            begin
                m_tready = 1'b0;
                while (hold_off > 0)
                begin
                    @(negedge clk);
                    hold_off--;
                end
            end
            m_tready = ($urandom_range(0, 4) == 0) ? 1'b0 : 1'b1;
            @(posedge clk);
            if (m_tvalid && m_tready)
                sb.check_result(m_tdata);
        end
    end

    initial
    begin
        int settings[$];
        sb       = new();
        hold_off = 0;
        sent     = 0;
        rst_n    = 1'b0;
        psel     = 1'b0;
        penable  = 1'b0;
        pwrite   = 1'b0;
        paddr    = '0;
        pwdata   = '0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tlast  = 1'b0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        repeat (2) @(negedge clk);

        // tree with ties, a self loop and out of range endpoints
        write_node_count(4);
        send_edge(1, 2, 0, 0);
        send_edge(2, 3, 65535, 0);
        send_edge(3, 4, 5, 0);
        send_edge(1, 4, 5, 0);
        send_edge(2, 2, 1, 0);
        send_edge(0, 3, 1, 0);
        send_edge(5, 1, 1, 0);
        send_edge(1023, 3, 1, 1);
        drain();
        // disconnected graph
        write_node_count(6);
        send_edge(1, 2, 3, 0);
        send_edge(4, 5, 9, 1);
        drain();
        // no nodes at all
        write_node_count(0);
        send_edge(1, 2, 7, 0);
        send_edge(0, 0, 7, 1);
        drain();
        write_node_count(1);
        send_edge(1, 1, 4, 1);
        drain();
        write_node_count(1023);
        send_edge(1023, 512, 65535, 0);
        send_edge(341, 682, 43690, 0);
        send_edge(682, 1023, 21845, 1);
        drain();

        settings = '{1, 2, 3, 5, 8, 12, 0, 1023, 6, 16};
        sent = 0;
        for (int p = 0; sent < 1450; p++)
        begin
            write_node_count(p < settings.size() ? settings[p] : $urandom_range(2, 16));
            // long receiver hold so the block backs up into the input
            if (p == 3)
                hold_off = 3000;
            repeat ($urandom_range(15, 25))
                random_list(sb.nodes);
            drain();
        end

        repeat (200) @(negedge clk);
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("tb_top: clean");
        else
            $display("tb_top: errors");
        $finish;
    end

    initial
    begin
        #200ms;
        $display("tb_top: errors");
        $finish;
    end

endmodule
